>>> rtl/core/oasp_pkg.sv
// Package for the overflow-aware stopwatch profiler core.
// Holds the operation codes, timing constants and controller/datapath structs.
// No dependencies.
package oasp_pkg;

    // Period of the free-running counter that the epoch extends
    localparam logic [31:0] COUNTER_PERIOD = 32'd65536;

    // Quotient bits produced by the average divider, one per cycle
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture the input transfer
        logic calc;      // epoch difference and partial elapsed terms
        logic update;    // apply operation, seed divider
        logic div_step;  // one restoring division step
        logic out_load;  // fill the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;  // output register empty or draining this cycle
    } t_dp_status;

endpackage

>>> rtl/core/oasp_if.sv
// Stream interfaces for the profiler core: input events and result items.
// Valid/ready handshake; depends on no package.
interface oasp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] counter_value;
    logic [31:0] epoch;

    modport source (output valid, output operation, output counter_value, output epoch,
                    input ready);
    modport sink   (input valid, input operation, input counter_value, input epoch,
                    output ready);
endinterface

interface oasp_out_if;
    logic        valid;
    logic        ready;
    logic        active;
    logic [31:0] current_ticks;
    logic [31:0] total_ticks;
    logic [15:0] iteration_count;
    logic [31:0] average_ticks;

    modport source (output valid, output active, output current_ticks, output total_ticks,
                    output iteration_count, output average_ticks, input ready);
    modport sink   (input valid, input active, input current_ticks, input total_ticks,
                    input iteration_count, input average_ticks, output ready);
endinterface

>>> rtl/core/oasp_ctrl.sv
// Sequencer for the profiler: capture, elapsed calc, update, divide, output.
// Depends on oasp_pkg.
module oasp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  oasp_pkg::t_dp_status i_status,
    output oasp_pkg::t_dp_cmd   o_cmd
);
    import oasp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_UPD,
        S_DIV,
        S_DONE
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_in_ready, n_in_ready;
    logic [DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic                   in_xfer;

    assign in_xfer    = i_in_valid && r_in_ready;
    assign o_in_ready = r_in_ready;

    always_comb begin
        n_state    = r_state;
        n_in_ready = r_in_ready;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    o_cmd.load = 1'b1;
                    n_in_ready = 1'b0;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_cnt        = '0;
                n_state      = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_in_ready     = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
            r_cnt      <= n_cnt;
        end
    end

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready |-> r_state == S_IDLE)
        else $error("input ready outside idle");

    a_div_full_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> ##(DIV_STEPS) (r_state == S_DONE))
        else $error("divider did not run the full step count");

endmodule

>>> rtl/core/oasp_datapath.sv
// Datapath for the profiler: stopwatch state, elapsed-tick arithmetic,
// restoring divider for the average, and the output register. Depends on oasp_pkg.
module oasp_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  oasp_pkg::t_dp_cmd    i_cmd,
    output oasp_pkg::t_dp_status o_status,
    input  logic [1:0]           i_operation,
    input  logic [15:0]          i_counter_value,
    input  logic [31:0]          i_epoch,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_active,
    output logic [31:0]          o_current_ticks,
    output logic [31:0]          o_total_ticks,
    output logic [15:0]          o_iteration_count,
    output logic [31:0]          o_average_ticks
);
    import oasp_pkg::*;

    // Captured transfer
    t_op         r_op;
    logic [15:0] r_cval;
    logic [31:0] r_ep;

    // Stopwatch state
    logic        r_running, n_running;
    logic [15:0] r_start_count, n_start_count;
    logic [31:0] r_start_epoch, n_start_epoch;
    logic [31:0] r_last, n_last;
    logic [31:0] r_acc, n_acc;
    logic [15:0] r_comp, n_comp;

    // Elapsed terms
    logic [31:0] r_prod, r_short, r_cur, n_cur;
    logic        r_gt1;
    logic [31:0] epoch_diff, elapsed;

    // Divider
    logic [31:0] r_quo;
    logic [15:0] r_rem;
    logic [16:0] trial;
    logic        q_bit;

    // Output register
    logic        r_out_valid;
    logic        r_out_active;
    logic [31:0] r_out_cur, r_out_total, r_out_avg;
    logic [15:0] r_out_count;

    assign epoch_diff = r_ep - r_start_epoch;
    assign elapsed    = r_gt1 ? r_prod + r_short : r_short;

    always_comb begin
        n_running     = r_running;
        n_start_count = r_start_count;
        n_start_epoch = r_start_epoch;
        n_last        = r_last;
        n_acc         = r_acc;
        n_comp        = r_comp;
        n_cur         = r_running ? elapsed : r_last;
        unique case (r_op)
            OP_CLEAR: begin
                n_running = 1'b0;
                n_last    = '0;
                n_acc     = '0;
                n_comp    = '0;
                n_cur     = '0;
            end
            OP_START: begin
                if (!r_running) begin
                    n_running     = 1'b1;
                    n_last        = '0;
                    n_start_count = r_cval;
                    n_start_epoch = r_ep;
                    n_cur         = '0;   // same reading as the start point
                end
            end
            OP_STOP: begin
                if (r_running) begin
                    n_running = 1'b0;
                    n_last    = elapsed;
                    n_acc     = r_acc + elapsed;
                    n_comp    = r_comp + 1'b1;
                    n_cur     = elapsed;
                end
            end
            OP_QUERY: ;
            default: ;
        endcase
    end

    assign trial = {r_rem, r_quo[31]};
    assign q_bit = trial >= {1'b0, r_comp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running     <= 1'b0;
            r_start_count <= '0;
            r_start_epoch <= '0;
            r_last        <= '0;
            r_acc         <= '0;
            r_comp        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                r_running     <= n_running;
                r_start_count <= n_start_count;
                r_start_epoch <= n_start_epoch;
                r_last        <= n_last;
                r_acc         <= n_acc;
                r_comp        <= n_comp;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_operation);
            r_cval <= i_counter_value;
            r_ep   <= i_epoch;
        end
        if (i_cmd.calc) begin
            r_gt1  <= epoch_diff > 32'd1;
            r_prod <= (epoch_diff - 32'd1) * COUNTER_PERIOD;
            // pending overflow shows as a reading below the start value
            if (epoch_diff != '0 || r_cval < r_start_count) begin
                r_short <= COUNTER_PERIOD - {16'd0, r_start_count} + {16'd0, r_cval};
            end else begin
                r_short <= {16'd0, r_cval} - {16'd0, r_start_count};
            end
        end
        if (i_cmd.update) begin
            r_cur <= n_cur;
            r_quo <= n_acc;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[30:0], q_bit};
            r_rem <= q_bit ? 16'(trial - {1'b0, r_comp}) : trial[15:0];
        end
        if (i_cmd.out_load) begin
            r_out_active <= r_running;
            r_out_cur    <= r_cur;
            r_out_total  <= r_acc;
            r_out_count  <= r_comp;
            r_out_avg    <= (r_comp == '0) ? '0 : r_quo;
        end
    end

    assign o_status.out_free = !r_out_valid || i_ready;
    assign o_valid           = r_out_valid;
    assign o_active          = r_out_active;
    assign o_current_ticks   = r_out_cur;
    assign o_total_ticks     = r_out_total;
    assign o_iteration_count = r_out_count;
    assign o_average_ticks   = r_out_avg;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> o_status.out_free)
        else $error("output register overwritten");

    a_clear_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && r_op == OP_CLEAR) |=> (!r_running && r_comp == '0))
        else $error("clear left state behind");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && r_op == OP_QUERY) |=> $stable(r_comp) && $stable(r_acc))
        else $error("query changed totals");

endmodule

>>> rtl/core/overflow_aware_stopwatch_profiler_core.sv
// Top level of the overflow-aware stopwatch profiler.
// Depends on oasp_pkg, oasp_if, oasp_ctrl and oasp_datapath.
//
//  port    dir  handshake     payload
//  i_in    in   valid/ready   operation, counter_value, epoch
//  o_out   out  valid/ready   active, current_ticks, total_ticks,
//                             iteration_count, average_ticks
//
// One item at a time; from input transfer to a valid result, when the output is
// free: elapsed calc, state update, the bit-serial restoring divider that forms
// the average, then the output load.
// Input ready returns with the output load; no new item is taken before it.
// Reset is synchronous, active low, and zeroes all stopwatch state.
// A result waits in the output register; the next input transfer is taken
// while it waits, and that item stalls only at its own output step.
module overflow_aware_stopwatch_profiler_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    oasp_in_if.sink    i_in,
    oasp_out_if.source o_out
);
    import oasp_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    oasp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    oasp_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_operation       (i_in.operation),
        .i_counter_value   (i_in.counter_value),
        .i_epoch           (i_in.epoch),
        .o_valid           (o_out.valid),
        .i_ready           (o_out.ready),
        .o_active          (o_out.active),
        .o_current_ticks   (o_out.current_ticks),
        .o_total_ticks     (o_out.total_ticks),
        .o_iteration_count (o_out.iteration_count),
        .o_average_ticks   (o_out.average_ticks)
    );

endmodule
